FILE: src/priority_message_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Priority message queue assertion macros
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_MESSAGE_QUEUE_TOP_MACROS_SVH
`define PRIORITY_MESSAGE_QUEUE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// check disabled while reset is low
`define PMQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pmq assertion failed");
// check active in every cycle, reset included
`define PMQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pmq assertion failed");
`else
`define PMQ_ASSERT(label, clk, rst_n, prop)
`define PMQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: src/pmq_pkg.sv
// ----------------------------------------------------------------------------
// Priority message queue package
// Shared codes, limits and command/result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pmq_pkg;

    localparam int PRIORITY_LEVELS  = 32768;
    localparam int SIGNAL_COUNT     = 65;
    localparam int DESCRIPTOR_COUNT = 256;

    localparam logic [2:0] FN_SEND   = 3'd0;
    localparam logic [2:0] FN_RECV   = 3'd1;
    localparam logic [2:0] FN_REG    = 3'd2;
    localparam logic [2:0] FN_CANCEL = 3'd3;
    localparam logic [2:0] FN_CLOSE  = 3'd4;

    localparam logic [1:0] AM_RDONLY = 2'd0;
    localparam logic [1:0] AM_WRONLY = 2'd1;
    localparam logic [1:0] AM_RDWR   = 2'd2;

    localparam logic [1:0] NK_NONE   = 2'd0;
    localparam logic [1:0] NK_SIGNAL = 2'd1;

    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_ACCESS = 4'd1;
    localparam logic [3:0] ST_LONG   = 4'd2;
    localparam logic [3:0] ST_PRIO   = 4'd3;
    localparam logic [3:0] ST_FULL   = 4'd4;
    localparam logic [3:0] ST_EMPTY  = 4'd5;
    localparam logic [3:0] ST_NOTIFY = 4'd6;
    localparam logic [3:0] ST_BUSY   = 4'd7;
    localparam logic [3:0] ST_SMALL  = 4'd8;

    localparam logic REG_MAX_MESSAGES = 1'b0;
    localparam logic REG_MESSAGE_SIZE = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  pre_status;
        logic [16:0] length;
        logic [14:0] prio;
        logic [15:0] req;
        logic [7:0]  desc;
        logic [1:0]  kind;
        logic [6:0]  signo;
        logic [63:0] sval;
        logic        waiting;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  slot_index;
        logic [14:0] message_priority;
        logic [16:0] message_length;
        logic [8:0]  message_count;
        logic        notify_fire;
        logic [15:0] notify_target;
        logic [6:0]  notify_signal;
        logic [63:0] notify_data;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEND,
        S_RECV,
        S_RECV_END,
        S_RECV_DEC,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

FILE: src/pmq_front.sv
// ----------------------------------------------------------------------------
// Priority message queue front end
// Holds configuration, accepts requests and runs the table-free checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pmq_front #(
    parameter int SLOT_LIMIT = 256,
    parameter int CW         = 9
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_addr,
    input  wire  [16:0]       i_cfg_data,
    input  wire  [2:0]        i_func,
    input  wire  [16:0]       i_length,
    input  wire  [14:0]       i_send_priority,
    input  wire  [1:0]        i_access_mode,
    input  wire  [15:0]       i_requester_id,
    input  wire  [7:0]        i_descriptor_id,
    input  wire  [1:0]        i_notify_kind,
    input  wire  [6:0]        i_signal_number,
    input  wire  [63:0]       i_signal_value,
    input  wire               i_receiver_waiting,
    output pmq_pkg::t_cmd     o_cmd,
    output logic [CW-1:0]     o_lim
);
    import pmq_pkg::*;

    logic [8:0]  r_max_messages;
    logic [16:0] r_message_size;
    logic [3:0]  pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_messages <= 9'd10;
            r_message_size <= 17'd8192;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_MAX_MESSAGES) begin
                r_max_messages <= i_cfg_data[8:0];
            end else begin
                r_message_size <= i_cfg_data;
            end
        end
    end

    assign o_lim = (32'(r_max_messages) > SLOT_LIMIT) ? CW'(SLOT_LIMIT) : CW'(r_max_messages);

    always_comb begin
        pre = ST_OK;
        if (i_func <= FN_CLOSE && 32'(i_descriptor_id) >= DESCRIPTOR_COUNT) begin
            pre = ST_ACCESS;
        end else if (i_func == FN_SEND) begin
            if (i_access_mode == AM_RDONLY) pre = ST_ACCESS;
            else if (i_length > r_message_size) pre = ST_LONG;
            else if (32'(i_send_priority) >= PRIORITY_LEVELS) pre = ST_PRIO;
        end else if (i_func == FN_RECV) begin
            if (i_access_mode == AM_WRONLY) pre = ST_ACCESS;
            else if (i_length < r_message_size) pre = ST_SMALL;
        end else if (i_func == FN_REG) begin
            if (i_notify_kind > NK_SIGNAL ||
                (i_notify_kind == NK_SIGNAL && 32'(i_signal_number) >= SIGNAL_COUNT))
                pre = ST_NOTIFY;
        end
    end

    always_comb begin
        o_cmd.func       = i_func;
        o_cmd.pre_status = pre;
        o_cmd.length     = i_length;
        o_cmd.prio       = i_send_priority;
        o_cmd.req        = i_requester_id;
        o_cmd.desc       = i_descriptor_id;
        o_cmd.kind       = i_notify_kind;
        o_cmd.signo      = i_signal_number;
        o_cmd.sval       = i_signal_value;
        o_cmd.waiting    = i_receiver_waiting;
    end
endmodule
`default_nettype wire

FILE: src/pmq_fifo.sv
// ----------------------------------------------------------------------------
// Priority message queue command FIFO
// Two-entry queue between the front end and the slot engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pmq_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  pmq_pkg::t_cmd  i_data,
    output logic           o_full,
    input  wire            i_pop,
    output pmq_pkg::t_cmd  o_data,
    output logic           o_empty
);
    import pmq_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

FILE: src/pmq_back.sv
// ----------------------------------------------------------------------------
// Priority message queue slot engine
// Owns the slot table and notification, scans slots, holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "priority_message_queue_top_macros.svh"
module pmq_back #(
    parameter int SLOT_LIMIT = 256,
    parameter int SW         = 8,
    parameter int CW         = 9
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  pmq_pkg::t_cmd  i_cmd,
    input  wire            i_cmd_empty,
    output logic           o_cmd_pop,
    input  wire  [CW-1:0]  i_lim,
    output pmq_pkg::t_res  o_res,
    output logic           o_empty,
    input  wire            i_pop
);
    import pmq_pkg::*;

    localparam int MW = 15 + 17 + 64;

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [CW-1:0]   r_cnt;
    logic [8:0]      r_held;
    logic [63:0]     r_next_order;
    logic            r_armed, r_by_signal;
    logic [15:0]     r_owner;
    logic [7:0]      r_ndesc;
    logic [6:0]      r_signo;
    logic [63:0]     r_word;
    logic [SLOT_LIMIT-1:0] r_used;
    logic [MW-1:0]   r_mem [SLOT_LIMIT];
    logic [MW-1:0]   r_rd_data;
    logic            r_rd_v, r_rd_used;
    logic [SW-1:0]   r_rd_idx;
    logic            r_found;
    logic [SW-1:0]   r_best_idx;
    logic [14:0]     r_best_prio;
    logic [16:0]     r_best_len;
    logic [63:0]     r_best_order;
    t_res            r_res;
    logic            r_out_v;
    t_res            r_out;

    logic [SW-1:0]   idx;
    logic            last;
    logic            free_hit;
    logic            out_load;
    logic            rd_issue;
    logic            mem_we;
    logic [14:0]     c_prio;
    logic [16:0]     c_len;
    logic [63:0]     c_order;
    logic            better;
    logic            fire_now;
    logic [3:0]      exec_st;

    assign idx      = r_cnt[SW-1:0];
    assign last     = (r_cnt == i_lim - CW'(1));
    assign free_hit = !r_used[idx];
    assign c_prio   = r_rd_data[MW-1 -: 15];
    assign c_len    = r_rd_data[63+17 -: 17];
    assign c_order  = r_rd_data[63:0];
    assign better   = r_rd_v && r_rd_used &&
                      (!r_found || c_prio > r_best_prio ||
                       (c_prio == r_best_prio && c_order < r_best_order));
    assign fire_now = (r_held == 9'd0) && r_armed && !r_cmd.waiting;

    // status known before any scan
    always_comb begin
        exec_st = ST_OK;
        if (r_cmd.pre_status != ST_OK) begin
            exec_st = r_cmd.pre_status;
        end else if (r_cmd.func == FN_SEND && 32'(r_held) >= 32'(i_lim)) begin
            exec_st = ST_FULL;
        end else if (r_cmd.func == FN_RECV && (r_held == 9'd0 || i_lim == '0)) begin
            exec_st = ST_EMPTY;
        end else if (r_cmd.func == FN_REG && r_armed) begin
            exec_st = ST_BUSY;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_cmd_empty) n_state = S_EXEC;
            S_EXEC: begin
                if (r_cmd.pre_status != ST_OK) n_state = S_EMIT;
                else if (r_cmd.func == FN_SEND)
                    n_state = (32'(r_held) >= 32'(i_lim)) ? S_EMIT : S_SEND;
                else if (r_cmd.func == FN_RECV)
                    n_state = (r_held == 9'd0 || i_lim == '0) ? S_EMIT : S_RECV;
                else n_state = S_EMIT;
            end
            S_SEND:     if (free_hit || last) n_state = S_EMIT;
            S_RECV:     if (last) n_state = S_RECV_END;
            S_RECV_END: n_state = S_RECV_DEC;
            S_RECV_DEC: n_state = S_EMIT;
            S_EMIT:     if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        out_load  = 1'b0;
        rd_issue  = 1'b0;
        mem_we    = 1'b0;
        unique case (r_state)
            S_IDLE: o_cmd_pop = !i_cmd_empty;
            S_SEND: mem_we    = free_hit;
            S_RECV: rd_issue  = 1'b1;
            S_EMIT: out_load  = !r_out_v || i_pop;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // slot attribute memory: priority, length, arrival order
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[idx] <= {r_cmd.prio, r_cmd.length, r_next_order};
        end
        r_rd_data <= r_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 9'd0;
            r_next_order <= 64'd1;
            r_armed      <= 1'b0;
            r_by_signal  <= 1'b0;
            r_owner      <= 16'd0;
            r_ndesc      <= 8'd0;
            r_signo      <= 7'd0;
            r_word       <= 64'd0;
            r_used       <= '0;
            r_rd_v       <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_rd_v    <= rd_issue;
            r_rd_used <= r_used[idx];
            r_rd_idx  <= idx;
            if (o_cmd_pop) r_cmd <= i_cmd;
            if (out_load) begin
                r_out   <= r_res;
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end

            if (better) begin
                r_found      <= 1'b1;
                r_best_idx   <= r_rd_idx;
                r_best_prio  <= c_prio;
                r_best_len   <= c_len;
                r_best_order <= c_order;
            end

            case (r_state)
                S_EXEC: begin
                    r_res   <= {exec_st, 8'd0, 15'd0, 17'd0, r_held, 1'b0, 16'd0, 7'd0, 64'd0};
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    if (r_cmd.pre_status == ST_OK) begin
                        if (r_cmd.func == FN_REG) begin
                            if (!r_armed) begin
                                r_armed     <= 1'b1;
                                r_by_signal <= (r_cmd.kind == NK_SIGNAL);
                                r_owner     <= r_cmd.req;
                                r_ndesc     <= r_cmd.desc;
                                r_signo     <= (r_cmd.kind == NK_SIGNAL) ? r_cmd.signo : 7'd0;
                                r_word      <= (r_cmd.kind == NK_SIGNAL) ? r_cmd.sval : 64'd0;
                            end
                        end else if (r_cmd.func == FN_CANCEL) begin
                            if (r_armed && r_owner == r_cmd.req) r_armed <= 1'b0;
                        end else if (r_cmd.func == FN_CLOSE) begin
                            if (r_armed && r_owner == r_cmd.req && r_ndesc == r_cmd.desc)
                                r_armed <= 1'b0;
                        end
                    end
                end
                S_SEND: begin
                    if (free_hit) begin
                        r_used[idx]         <= 1'b1;
                        r_next_order        <= r_next_order + 64'd1;
                        r_held              <= r_held + 9'd1;
                        r_res.slot_index    <= 8'(idx);
                        r_res.message_count <= r_held + 9'd1;
                        if (fire_now) begin
                            r_armed <= 1'b0;
                            if (r_by_signal) begin
                                r_res.notify_fire   <= 1'b1;
                                r_res.notify_target <= r_owner;
                                r_res.notify_signal <= r_signo;
                                r_res.notify_data   <= r_word;
                            end
                        end
                    end else if (last) begin
                        r_res.status <= ST_FULL;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_RECV: r_cnt <= r_cnt + CW'(1);
                S_RECV_DEC: begin
                    if (!r_found) begin
                        r_res.status <= ST_EMPTY;
                    end else if (r_best_len > r_cmd.length) begin
                        r_res.status <= ST_SMALL;
                    end else begin
                        r_used[r_best_idx]     <= 1'b0;
                        r_held                 <= r_held - 9'd1;
                        r_res.slot_index       <= 8'(r_best_idx);
                        r_res.message_priority <= r_best_prio;
                        r_res.message_length   <= r_best_len;
                        r_res.message_count    <= r_held - 9'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res   = r_out;
    assign o_empty = !r_out_v;

    `PMQ_ASSERT(a_held_in_range, i_clk, i_rst_n, 32'(r_held) <= SLOT_LIMIT)
    `PMQ_ASSERT(a_fire_only_ok, i_clk, i_rst_n, (r_out_v && r_out.notify_fire) |-> (r_out.status == ST_OK))
    `PMQ_ASSERT(a_start_exec, i_clk, i_rst_n, (r_state == S_IDLE && !i_cmd_empty) |=> (r_state == S_EXEC))
    `PMQ_ASSERT_ALWAYS(a_rd_after_recv, i_clk, (i_rst_n && r_rd_v) |-> ($past(r_state) == S_RECV))
endmodule
`default_nettype wire

FILE: src/priority_message_queue_top.sv
// Cancel, close, notify, unknown and rejected requests, a send when full and a receive
// when empty go straight to the result; else a send scans to the first free slot and a
// receive all lim slots, lim = min(max_messages, SLOT_LIMIT). A full result register stalls.
// Throughput: one request at a time in the slot engine, which scans one slot per cycle
// through the used bits (send) or the slot attribute memory read port (receive).
// Reset (synchronous, active low) empties the table, disarms notification, sets
// max_messages 10 and message_size 8192; the used bits clear at once, no sweep.
// ----------------------------------------------------------------------------
// Priority message queue top level
// Front checks, command FIFO and slot engine with a one-entry result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module priority_message_queue_top #(
    parameter int SLOT_LIMIT = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_addr,
    input  wire  [16:0] i_cfg_data,
    input  wire         push,
    output logic        full,
    input  wire  [2:0]  i_func,
    input  wire  [16:0] i_length,
    input  wire  [14:0] i_send_priority,
    input  wire  [1:0]  i_access_mode,
    input  wire  [15:0] i_requester_id,
    input  wire  [7:0]  i_descriptor_id,
    input  wire  [1:0]  i_notify_kind,
    input  wire  [6:0]  i_signal_number,
    input  wire  [63:0] i_signal_value,
    input  wire         i_receiver_waiting,
    output logic        empty,
    input  wire         pop,
    output logic [3:0]  o_status,
    output logic [7:0]  o_slot_index,
    output logic [14:0] o_message_priority,
    output logic [16:0] o_message_length,
    output logic [8:0]  o_message_count,
    output logic        o_notify_fire,
    output logic [15:0] o_notify_target,
    output logic [6:0]  o_notify_signal,
    output logic [63:0] o_notify_data
);
    import pmq_pkg::*;

    localparam int SW = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;
    localparam int CW = $clog2(SLOT_LIMIT + 1);

    t_cmd          f_cmd;
    t_cmd          q_cmd;
    logic [CW-1:0] lim;
    logic          q_empty;
    logic          q_pop;
    t_res          res;

    pmq_front #(.SLOT_LIMIT(SLOT_LIMIT), .CW(CW)) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_func             (i_func),
        .i_length           (i_length),
        .i_send_priority    (i_send_priority),
        .i_access_mode      (i_access_mode),
        .i_requester_id     (i_requester_id),
        .i_descriptor_id    (i_descriptor_id),
        .i_notify_kind      (i_notify_kind),
        .i_signal_number    (i_signal_number),
        .i_signal_value     (i_signal_value),
        .i_receiver_waiting (i_receiver_waiting),
        .o_cmd              (f_cmd),
        .o_lim              (lim)
    );

    pmq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    pmq_back #(.SLOT_LIMIT(SLOT_LIMIT), .SW(SW), .CW(CW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_lim       (lim),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_status           = res.status;
    assign o_slot_index       = res.slot_index;
    assign o_message_priority = res.message_priority;
    assign o_message_length   = res.message_length;
    assign o_message_count    = res.message_count;
    assign o_notify_fire      = res.notify_fire;
    assign o_notify_target    = res.notify_target;
    assign o_notify_signal    = res.notify_signal;
    assign o_notify_data      = res.notify_data;
endmodule
`default_nettype wire

FILE: dv/tb_priority_message_queue_top.sv
// ----------------------------------------------------------------------------
// Priority message queue testbench
// Directed table, then shaped random traffic over several register settings.
// A local slot-table predictor produces the expected result of every
// accepted request; results are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_priority_message_queue_top;
    import pmq_pkg::*;

    typedef struct {
        logic [2:0]  func;
        logic [16:0] length;
        logic [14:0] prio;
        logic [1:0]  mode;
        logic [15:0] req;
        logic [7:0]  desc;
        logic [1:0]  kind;
        logic [6:0]  signo;
        logic [63:0] sval;
        logic        waiting;
    } mq_req_t;

    typedef struct {
        mq_req_t     rq;
        bit          typed;
        logic [3:0]  st;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [16:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty;
    mq_req_t     drv;
    logic [3:0]  o_status;
    logic [7:0]  o_slot_index;
    logic [14:0] o_message_priority;
    logic [16:0] o_message_length;
    logic [8:0]  o_message_count;
    logic        o_notify_fire;
    logic [15:0] o_notify_target;
    logic [6:0]  o_notify_signal;
    logic [63:0] o_notify_data;

    initial drv = '{default: '0};

    priority_message_queue_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_func(drv.func), .i_length(drv.length), .i_send_priority(drv.prio),
        .i_access_mode(drv.mode), .i_requester_id(drv.req),
        .i_descriptor_id(drv.desc), .i_notify_kind(drv.kind),
        .i_signal_number(drv.signo), .i_signal_value(drv.sval),
        .i_receiver_waiting(drv.waiting),
        .empty(empty), .pop(pop),
        .o_status(o_status), .o_slot_index(o_slot_index),
        .o_message_priority(o_message_priority), .o_message_length(o_message_length),
        .o_message_count(o_message_count), .o_notify_fire(o_notify_fire),
        .o_notify_target(o_notify_target), .o_notify_signal(o_notify_signal),
        .o_notify_data(o_notify_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // slot table mirror
    bit          used_map [256];
    logic [14:0] prio_mem [256];
    logic [16:0] len_mem [256];
    logic [63:0] order_mem [256];
    logic [63:0] arrival_ctr;
    logic [8:0]  held;
    bit          armed, by_signal;
    logic [15:0] owner;
    logic [7:0]  owner_desc;
    logic [6:0]  armed_signo;
    logic [63:0] armed_word;
    logic [8:0]  cap_cfg;
    logic [16:0] size_cfg;

    t_res        pending_results [$];
    int          errors = 0;

    task automatic report(string what, logic [63:0] got, logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
        errors++;
    endtask

    function automatic t_res queue_step(mq_req_t r);
        t_res   res;
        int     lim;
        int     pick;
        bit     found;
        res = '0;
        lim = (cap_cfg > 256) ? 256 : int'(cap_cfg);
        found = 0;
        pick = 0;
        res.status = ST_OK;
        case (r.func)
            FN_SEND: begin
                if (r.mode == AM_RDONLY) res.status = ST_ACCESS;
                else if (r.length > size_cfg) res.status = ST_LONG;
                else if (int'(r.prio) >= PRIORITY_LEVELS) res.status = ST_PRIO;
                else begin
                    if (held < lim)
                        for (int i = 0; i < lim && !found; i++)
                            if (!used_map[i]) begin
                                pick = i;
                                found = 1;
                            end
                    if (!found) res.status = ST_FULL;
                    else begin
                        used_map[pick] = 1;
                        prio_mem[pick] = r.prio;
                        len_mem[pick] = r.length;
                        order_mem[pick] = arrival_ctr;
                        arrival_ctr++;
                        res.slot_index = pick[7:0];
                        if (held == 0 && armed && !r.waiting) begin
                            if (by_signal) begin
                                res.notify_fire = 1'b1;
                                res.notify_target = owner;
                                res.notify_signal = armed_signo;
                                res.notify_data = armed_word;
                            end
                            armed = 0;
                        end
                        held++;
                    end
                end
            end
            FN_RECV: begin
                if (r.mode == AM_WRONLY) res.status = ST_ACCESS;
                else if (r.length < size_cfg) res.status = ST_SMALL;
                else begin
                    if (held != 0)
                        for (int i = 0; i < lim; i++)
                            if (used_map[i] && (!found || prio_mem[i] > prio_mem[pick] ||
                                (prio_mem[i] == prio_mem[pick] &&
                                 order_mem[i] < order_mem[pick]))) begin
                                pick = i;
                                found = 1;
                            end
                    if (!found) res.status = ST_EMPTY;
                    else if (len_mem[pick] > r.length) res.status = ST_SMALL;
                    else begin
                        res.slot_index = pick[7:0];
                        res.message_priority = prio_mem[pick];
                        res.message_length = len_mem[pick];
                        used_map[pick] = 0;
                        held--;
                    end
                end
            end
            FN_REG: begin
                if (r.kind > NK_SIGNAL || (r.kind == NK_SIGNAL && r.signo >= SIGNAL_COUNT))
                    res.status = ST_NOTIFY;
                else if (armed) res.status = ST_BUSY;
                else begin
                    armed = 1;
                    by_signal = (r.kind == NK_SIGNAL);
                    owner = r.req;
                    owner_desc = r.desc;
                    armed_signo = by_signal ? r.signo : '0;
                    armed_word = by_signal ? r.sval : '0;
                end
            end
            FN_CANCEL: if (armed && owner == r.req) armed = 0;
            FN_CLOSE: if (armed && owner == r.req && owner_desc == r.desc) armed = 0;
            default: ;
        endcase
        res.message_count = held;
        return res;
    endfunction

    task automatic send_request(mq_req_t r, bit typed, logic [3:0] st);
        t_res exp;
        repeat ($urandom_range(0, 9)) @(negedge i_clk);
        drv = r;
        push = 1'b1;
        do @(posedge i_clk); while (full);
        exp = queue_step(r);
        if (typed) exp.status = st;
        pending_results.push_back(exp);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic drain;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr, logic [16:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (addr == REG_MAX_MESSAGES) cap_cfg = val[8:0];
        else size_cfg = val;
    endtask

    function automatic mq_req_t draw_request();
        mq_req_t r;
        int      sel;
        r.func = 3'($urandom_range(0, 7));
        r.length = 17'($urandom_range(0, 65536));
        r.prio = 15'($urandom);
        r.mode = 2'($urandom);
        r.req = 16'($urandom);
        r.desc = 8'($urandom);
        r.kind = 2'($urandom);
        r.signo = 7'($urandom);
        r.sval = {$urandom, $urandom};
        r.waiting = 1'($urandom);
        if ($urandom_range(0, 9) == 0) return r;   // raw noise
        sel = $urandom_range(0, 99);
        if (sel < 42) r.func = FN_SEND;
        else if (sel < 80) r.func = FN_RECV;
        else if (sel < 90) r.func = FN_REG;
        else if (sel < 95) r.func = FN_CANCEL;
        else r.func = FN_CLOSE;
        if ($urandom_range(0, 9) != 0) r.mode = (r.func == FN_SEND) ? AM_RDWR : 2'($urandom_range(2, 3));
        if (r.func == FN_SEND && $urandom_range(0, 9) != 0)
            r.length = 17'($urandom_range(0, int'(size_cfg)));
        if (r.func == FN_RECV && $urandom_range(0, 9) != 0)
            r.length = ($urandom_range(0, 1) || size_cfg > 65000) ? size_cfg :
                       17'($urandom_range(int'(size_cfg), 65536));
        if ($urandom_range(0, 3) != 0) r.prio = 15'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) r.req = 16'($urandom_range(1, 3));
        if ($urandom_range(0, 3) != 0) r.desc = 8'($urandom_range(0, 2));
        if (r.func == FN_REG && $urandom_range(0, 3) != 0) begin
            r.kind = 2'($urandom_range(0, 1));
            r.signo = 7'($urandom_range(0, SIGNAL_COUNT - 1));
        end
        return r;
    endfunction

    // result side: random stall per transfer, in-order compare
    initial begin
        t_res e;
        @(posedge i_rst_n);
        forever begin
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_results.size() == 0) begin
                report("unexpected status", o_status, 64'd0);
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status) report("status", o_status, e.status);
                if (o_slot_index !== e.slot_index) report("slot", o_slot_index, e.slot_index);
                if (o_message_priority !== e.message_priority)
                    report("priority", o_message_priority, e.message_priority);
                if (o_message_length !== e.message_length)
                    report("length", o_message_length, e.message_length);
                if (o_message_count !== e.message_count)
                    report("count", o_message_count, e.message_count);
                if (o_notify_fire !== e.notify_fire) report("fire", o_notify_fire, e.notify_fire);
                if (o_notify_target !== e.notify_target)
                    report("target", o_notify_target, e.notify_target);
                if (o_notify_signal !== e.notify_signal)
                    report("signal", o_notify_signal, e.notify_signal);
                if (o_notify_data !== e.notify_data)
                    report("value", o_notify_data, e.notify_data);
            end
            @(negedge i_clk);
            pop = 1'b0;
        end
    end

    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        dir_row_t    rows [$];
        mq_req_t     b;
        logic [8:0]  caps [7];
        logic [16:0] sizes [7];
        caps = '{9'd1, 9'd256, 9'd3, 9'd511, 9'd0, 9'd64, 9'd10};
        sizes = '{17'd1, 17'd65536, 17'd100, 17'd20, 17'd50, 17'd1000, 17'd8192};
        foreach (used_map[i]) used_map[i] = 0;
        arrival_ctr = 64'd1;
        held = '0;
        armed = 0;
        by_signal = 0;
        owner = '0;
        owner_desc = '0;
        armed_signo = '0;
        armed_word = '0;
        cap_cfg = 9'd10;
        size_cfg = 17'd8192;

        b = '{func: FN_RECV, length: 17'd8192, prio: '0, mode: AM_RDWR, req: 16'd7,
              desc: 8'd3, kind: NK_NONE, signo: '0, sval: '0, waiting: 1'b0};
        rows.push_back('{b, 1, ST_EMPTY});
        b.func = FN_SEND; b.mode = AM_RDONLY;
        rows.push_back('{b, 1, ST_ACCESS});
        b.mode = AM_RDWR; b.length = 17'd8193;
        rows.push_back('{b, 1, ST_LONG});
        b.func = FN_REG; b.kind = 2'd2;
        rows.push_back('{b, 1, ST_NOTIFY});
        b.kind = 2'd3;
        rows.push_back('{b, 1, ST_NOTIFY});
        b.kind = NK_SIGNAL; b.signo = 7'd65;
        rows.push_back('{b, 1, ST_NOTIFY});
        b.signo = 7'd64; b.sval = '1;
        rows.push_back('{b, 1, ST_OK});
        rows.push_back('{b, 1, ST_BUSY});
        b.func = FN_SEND; b.length = 17'd8192; b.prio = 15'h7FFF; b.req = 16'hFFFF;
        rows.push_back('{b, 0, ST_OK});          // fires the signal
        b.length = 17'd0; b.prio = 15'd0; b.mode = 2'd3;
        rows.push_back('{b, 0, ST_OK});
        b.prio = 15'h7FFF; b.mode = AM_WRONLY;
        rows.push_back('{b, 0, ST_OK});
        b.func = FN_RECV;
        rows.push_back('{b, 1, ST_ACCESS});
        b.mode = AM_RDONLY; b.length = 17'd8191;
        rows.push_back('{b, 1, ST_SMALL});
        b.length = 17'd65536;
        rows.push_back('{b, 0, ST_OK});
        b.func = FN_REG; b.kind = NK_NONE; b.req = 16'd5; b.desc = 8'hFF;
        rows.push_back('{b, 1, ST_OK});
        b.func = FN_CANCEL; b.req = 16'd6;
        rows.push_back('{b, 1, ST_OK});          // not the owner
        b.func = FN_CLOSE; b.req = 16'd5; b.desc = 8'd0;
        rows.push_back('{b, 1, ST_OK});          // wrong descriptor
        b.func = FN_RECV; b.mode = AM_RDWR;
        rows.push_back('{b, 0, ST_OK});
        rows.push_back('{b, 0, ST_OK});
        b.func = FN_SEND; b.waiting = 1'b1; b.length = 17'd100;
        rows.push_back('{b, 0, ST_OK});          // receiver waiting: no notify
        b.func = FN_RECV; b.length = 17'd65536;
        rows.push_back('{b, 0, ST_OK});
        b.func = FN_SEND; b.waiting = 1'b0; b.length = 17'd100;
        rows.push_back('{b, 0, ST_OK});          // kind none consumed silently
        b.func = 3'd5;
        rows.push_back('{b, 1, ST_OK});
        b.func = 3'd7;
        rows.push_back('{b, 1, ST_OK});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].st);
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_MAX_MESSAGES, {8'd0, caps[ph]});
            write_reg(REG_MESSAGE_SIZE, sizes[ph]);
            repeat (160) send_request(draw_request(), 0, ST_OK);
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/pmq_pkg.sv
src/pmq_front.sv
src/pmq_fifo.sv
src/pmq_back.sv
src/priority_message_queue_top.sv
dv/tb_priority_message_queue_top.sv
